// ===== rtl/assert_macros.svh =====
// Assertion macros used by the RTL core of the ticket queue scheduler.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define TCQ_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define TCQ_NEVER(lbl, clk, rst_n, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define TCQ_ASSERT(lbl, clk, rst_n, prop, msg)
`define TCQ_NEVER(lbl, clk, rst_n, expr, msg)
`endif
`endif

// ===== rtl/tcq_pkg.sv =====
// Types and constants of the two-class ticket queue scheduler.
package tcq_pkg;
	localparam int DEF_QUEUE_DEPTH = 128;
	localparam int NUM_W = 16;
	localparam int TOD_W = 17;
	localparam int WAIT_W = 8;
	localparam int CNT32_W = 32;
	localparam int BURST_W = 4;
	localparam logic [BURST_W-1:0] BURST_RESET = 4'd2;
	localparam logic [BURST_W-1:0] RUN_MAX = 4'd15;
	localparam logic [NUM_W-1:0] TICKET_FIRST = 16'd1;
	localparam logic [NUM_W-1:0] TICKET_LAST = 16'hFFFF;

	typedef enum logic [1:0] {
		ACT_ISSUE  = 2'd0,
		ACT_CALL   = 2'd1,
		ACT_SEARCH = 2'd2,
		ACT_CANCEL = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_FULL      = 2'd1,
		ST_EMPTY     = 2'd2,
		ST_NOT_FOUND = 2'd3
	} status_t;

	localparam logic CLS_NORMAL = 1'b0;
	localparam logic CLS_PREF = 1'b1;

	typedef struct packed {
		logic [NUM_W-1:0] num;
		logic [TOD_W-1:0] tm;
	} entry_t;
endpackage

// ===== rtl/tcq_req_if.sv =====
// Request channel of the ticket queue scheduler.
interface tcq_req_if import tcq_pkg::*; ();
	logic valid;
	logic ready;
	logic [1:0] action;
	logic ticket_class;
	logic [NUM_W-1:0] ticket_number;
	logic [TOD_W-1:0] time_of_day;
	modport source (output valid, action, ticket_class, ticket_number, time_of_day,
		input ready);
	modport sink (input valid, action, ticket_class, ticket_number, time_of_day,
		output ready);
endinterface

// ===== rtl/tcq_rsp_if.sv =====
// Response channel of the ticket queue scheduler.
interface tcq_rsp_if import tcq_pkg::*; ();
	logic valid;
	logic ready;
	logic [1:0] status;
	logic result_class;
	logic [NUM_W-1:0] result_number;
	logic [TOD_W-1:0] result_time;
	logic [WAIT_W-1:0] normal_waiting;
	logic [WAIT_W-1:0] preferential_waiting;
	logic [CNT32_W-1:0] served_count;
	logic [CNT32_W-1:0] served_normal_count;
	logic [CNT32_W-1:0] served_preferential_count;
	logic [CNT32_W-1:0] cancelled_count;
	modport source (output valid, status, result_class, result_number, result_time,
		normal_waiting, preferential_waiting, served_count, served_normal_count,
		served_preferential_count, cancelled_count, input ready);
	modport sink (input valid, status, result_class, result_number, result_time,
		normal_waiting, preferential_waiting, served_count, served_normal_count,
		served_preferential_count, cancelled_count, output ready);
endinterface

// ===== rtl/tcq_cfg_if.sv =====
// Configuration write channel of the ticket queue scheduler.
interface tcq_cfg_if import tcq_pkg::*; ();
	logic valid;
	logic ready;
	logic [BURST_W-1:0] data;
	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

// ===== rtl/tcq_mem.sv =====
// Ticket store of both classes: one write port, one registered read port.
module tcq_mem import tcq_pkg::*; #(
	parameter int ADDR_W = 8
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  entry_t            wr_data,
	input  logic [ADDR_W-1:0] rd_addr,
	output entry_t            rd_data
);
	entry_t mem_q [2**ADDR_W];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end
endmodule

// ===== rtl/two_class_ticket_queue_scheduler_core.sv =====
// Two-class ticket queue scheduler: top level with sequencer and counters.
//
// Requests come in on the request channel (valid/ready); each yields one
// response on the response channel. The config channel writes normal_burst,
// the number of normal tickets called in a row before one preferential one;
// it is always ready and must only be written while the block is idle.
// Issue writes the ticket store once; call reads the head entry. Search
// and cancel step one shared slot adder and the single read port of the
// ticket store through the queue, examining one entry after another;
// cancel then reads and writes each later entry to move it up one place.
// One request is processed at a time; request.ready is high only
// while the sequencer is idle. A finished response sits in an output
// register, and a new request is taken while it waits; if the next response
// is done before the old one is taken, the sequencer holds it.
// Reset empties both queues, sets both ticket numbers to 1, clears the
// counters and sets normal_burst to 2. No clearing pass is needed.
`include "assert_macros.svh"
module two_class_ticket_queue_scheduler_core import tcq_pkg::*; #(
	parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
	input logic clk,
	input logic arst_n,
	tcq_req_if.sink request,
	tcq_rsp_if.source response,
	tcq_cfg_if.sink cfg
);
	localparam int IDX_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam int SUM_W = CNT_W + 1;
	localparam logic [SUM_W-1:0] DEPTH_S = SUM_W'(QUEUE_DEPTH);
	localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(QUEUE_DEPTH);

	typedef enum logic [3:0] {
		S_IDLE, S_ISS_WR, S_CALL_RD, S_CALL_WT, S_SC_RD, S_SC_CMP,
		S_SH_RD, S_SH_WR, S_DONE
	} state_t;

	state_t state_q;
	logic act_cancel_q;
	logic cls_q;
	logic [NUM_W-1:0] num_q;
	logic [TOD_W-1:0] tod_q;
	logic [CNT_W-1:0] k_q;
	logic [IDX_W-1:0] head_q [2];
	logic [CNT_W-1:0] fill_q [2];
	logic [NUM_W-1:0] next_tkt_q [2];
	logic [BURST_W-1:0] run_q, burst_q;
	logic [CNT32_W-1:0] served_q, served_n_q, served_p_q, cancelled_q;
	logic [IDX_W-1:0] addr_q, dst_q;
	logic [1:0] res_status_q;
	logic res_cls_q;
	entry_t res_q;
	logic out_valid_q;

	// Shared slot unit: (head + offset) modulo the queue depth.
	logic [SUM_W-1:0] slot_sum;
	logic [IDX_W-1:0] slot_idx;
	entry_t rd_data, wr_data;
	logic wr_en;
	logic [IDX_W:0] wr_addr;

	always_comb begin
		slot_sum = SUM_W'(head_q[cls_q]) + SUM_W'(k_q);
		if (slot_sum >= DEPTH_S) begin
			slot_sum = slot_sum - DEPTH_S;
		end
		slot_idx = IDX_W'(slot_sum);
	end

	always_comb begin
		wr_en = 1'b0;
		wr_addr = {cls_q, slot_idx};
		wr_data = rd_data;
		if (state_q == S_ISS_WR) begin
			wr_en = 1'b1;
			wr_data = '{num: next_tkt_q[cls_q], tm: tod_q};
		end else if (state_q == S_SH_WR) begin
			wr_en = 1'b1;
			wr_addr = {cls_q, dst_q};
		end
	end

	tcq_mem #(.ADDR_W(IDX_W + 1)) u_mem (
		.clk(clk),
		.wr_en(wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_addr({cls_q, slot_idx}),
		.rd_data(rd_data)
	);

	assign request.ready = (state_q == S_IDLE);
	assign cfg.ready = 1'b1;
	assign response.valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			head_q <= '{default: '0};
			fill_q <= '{default: '0};
			next_tkt_q <= '{default: TICKET_FIRST};
			run_q <= '0;
			burst_q <= BURST_RESET;
			served_q <= '0;
			served_n_q <= '0;
			served_p_q <= '0;
			cancelled_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg.valid) begin
				burst_q <= cfg.data;
			end
			// In S_DONE the output register is either reloaded or left waiting.
			if (out_valid_q && response.ready && state_q != S_DONE) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (request.valid) begin
						act_cancel_q <= (action_t'(request.action) == ACT_CANCEL);
						cls_q <= request.ticket_class;
						num_q <= request.ticket_number;
						tod_q <= request.time_of_day;
						res_cls_q <= request.ticket_class;
						res_status_q <= ST_OK;
						res_q <= '0;
						k_q <= '0;
						case (action_t'(request.action))
							ACT_ISSUE: begin
								if (fill_q[request.ticket_class] >= DEPTH_C) begin
									res_status_q <= ST_FULL;
									state_q <= S_DONE;
								end else begin
									k_q <= fill_q[request.ticket_class];
									state_q <= S_ISS_WR;
								end
							end
							ACT_CALL: begin
								if (fill_q[0] == '0 && fill_q[1] == '0) begin
									res_status_q <= ST_EMPTY;
									res_cls_q <= CLS_NORMAL;
									state_q <= S_DONE;
								end else begin
									// A class that is alone is served directly.
									if (fill_q[0] == '0) begin
										cls_q <= CLS_PREF;
									end else if (fill_q[1] == '0) begin
										cls_q <= CLS_NORMAL;
									end else begin
										cls_q <= (run_q < burst_q) ? CLS_NORMAL : CLS_PREF;
									end
									state_q <= S_CALL_RD;
								end
							end
							default: begin
								state_q <= S_SC_RD;
							end
						endcase
					end
				end
				S_ISS_WR: begin
					res_q <= '{num: next_tkt_q[cls_q], tm: tod_q};
					next_tkt_q[cls_q] <= (next_tkt_q[cls_q] == TICKET_LAST) ? TICKET_FIRST
						: next_tkt_q[cls_q] + 1'b1;
					fill_q[cls_q] <= fill_q[cls_q] + 1'b1;
					state_q <= S_DONE;
				end
				S_CALL_RD: begin
					// The head entry is being read; k_q is set so that the adder yields head + 1 in S_CALL_WT.
					k_q <= CNT_W'(1);
					state_q <= S_CALL_WT;
				end
				S_CALL_WT: begin
					res_q <= rd_data;
					res_cls_q <= cls_q;
					head_q[cls_q] <= slot_idx;
					fill_q[cls_q] <= fill_q[cls_q] - 1'b1;
					served_q <= served_q + 1'b1;
					if (cls_q == CLS_PREF) begin
						run_q <= '0;
						served_p_q <= served_p_q + 1'b1;
					end else begin
						if (run_q < RUN_MAX) begin
							run_q <= run_q + 1'b1;
						end
						served_n_q <= served_n_q + 1'b1;
					end
					state_q <= S_DONE;
				end
				S_SC_RD: begin
					if (k_q >= fill_q[cls_q]) begin
						res_status_q <= ST_NOT_FOUND;
						state_q <= S_DONE;
					end else begin
						addr_q <= slot_idx;
						state_q <= S_SC_CMP;
					end
				end
				S_SC_CMP: begin
					k_q <= k_q + 1'b1;
					if (rd_data.num == num_q) begin
						res_q <= rd_data;
						dst_q <= addr_q;
						state_q <= act_cancel_q ? S_SH_RD : S_DONE;
					end else begin
						state_q <= S_SC_RD;
					end
				end
				S_SH_RD: begin
					// Later entries move up one place to close the gap.
					if (k_q >= fill_q[cls_q]) begin
						fill_q[cls_q] <= fill_q[cls_q] - 1'b1;
						cancelled_q <= cancelled_q + 1'b1;
						state_q <= S_DONE;
					end else begin
						addr_q <= slot_idx;
						state_q <= S_SH_WR;
					end
				end
				S_SH_WR: begin
					dst_q <= addr_q;
					k_q <= k_q + 1'b1;
					state_q <= S_SH_RD;
				end
				S_DONE: begin
					if (!out_valid_q || response.ready) begin
						out_valid_q <= 1'b1;
						response.status <= res_status_q;
						response.result_class <= res_cls_q;
						response.result_number <= res_q.num;
						response.result_time <= res_q.tm;
						response.normal_waiting <= WAIT_W'(fill_q[0]);
						response.preferential_waiting <= WAIT_W'(fill_q[1]);
						response.served_count <= served_q;
						response.served_normal_count <= served_n_q;
						response.served_preferential_count <= served_p_q;
						response.cancelled_count <= cancelled_q;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	`TCQ_NEVER(a_fill_n, clk, arst_n, fill_q[0] > DEPTH_C, "normal fill beyond depth")
	`TCQ_NEVER(a_fill_p, clk, arst_n, fill_q[1] > DEPTH_C, "preferential fill beyond depth")
	`TCQ_ASSERT(a_busy, clk, arst_n, request.valid && request.ready |=> state_q != S_IDLE, "sequencer did not start")
	`TCQ_ASSERT(a_load, clk, arst_n, state_q == S_DONE && !out_valid_q |=> out_valid_q, "response not loaded")
endmodule

// ===== sim/tb_two_class_ticket_queue_scheduler_core.sv =====
// Randomized self-checking testbench of the two-class ticket queue scheduler core.
`timescale 1ns / 1ps
module tb_two_class_ticket_queue_scheduler_core;
	import tcq_pkg::*;

	localparam int DEPTH = DEF_QUEUE_DEPTH;
	localparam int WATCHDOG_LIMIT = 20000;
	localparam int HOLD_OFF_LEN = 400;

	typedef struct packed {
		status_t status;
		logic cls;
		logic [NUM_W-1:0] num;
		logic [TOD_W-1:0] tm;
		logic [WAIT_W-1:0] n_wait;
		logic [WAIT_W-1:0] p_wait;
		logic [31:0] served;
		logic [31:0] served_n;
		logic [31:0] served_p;
		logic [31:0] cancelled;
	} outcome_t;

	class ticket_scoreboard;
		entry_t queue_n[$];
		entry_t queue_p[$];
		logic [NUM_W-1:0] next_n, next_p;
		logic [BURST_W-1:0] burst, run;
		logic [31:0] served, served_n, served_p, cancelled;
		outcome_t pending[$];
		int mismatches;

		function new();
			next_n = TICKET_FIRST;
			next_p = TICKET_FIRST;
			burst = BURST_RESET;
			run = '0;
			served = 0;
			served_n = 0;
			served_p = 0;
			cancelled = 0;
			mismatches = 0;
		endfunction

		function int fill(logic c);
			return c ? queue_p.size() : queue_n.size();
		endfunction

		// Models one accepted request and queues the response it must produce.
		function void note_request(action_t act, logic c, logic [NUM_W-1:0] n,
				logic [TOD_W-1:0] tod);
			outcome_t o;
			entry_t e;
			int k;
			logic from;
			o.status = ST_OK;
			o.cls = CLS_NORMAL;
			o.num = '0;
			o.tm = '0;
			case (act)
				ACT_ISSUE: begin
					o.cls = c;
					if (fill(c) >= DEPTH) begin
						o.status = ST_FULL;
					end else begin
						e.num = c ? next_p : next_n;
						e.tm = tod;
						if (c) begin
							queue_p.push_back(e);
							next_p = (next_p == TICKET_LAST) ? TICKET_FIRST : next_p + 1'b1;
						end else begin
							queue_n.push_back(e);
							next_n = (next_n == TICKET_LAST) ? TICKET_FIRST : next_n + 1'b1;
						end
						o.num = e.num;
						o.tm = e.tm;
					end
				end
				ACT_CALL: begin
					if (queue_n.size() == 0 && queue_p.size() == 0) begin
						o.status = ST_EMPTY;
					end else begin
						if (queue_n.size() == 0) from = CLS_PREF;
						else if (queue_p.size() == 0) from = CLS_NORMAL;
						else from = (run < burst) ? CLS_NORMAL : CLS_PREF;
						if (from) begin
							e = queue_p.pop_front();
							run = '0;
							served_p++;
						end else begin
							e = queue_n.pop_front();
							if (run != RUN_MAX) run++;
							served_n++;
						end
						served++;
						o.cls = from;
						o.num = e.num;
						o.tm = e.tm;
					end
				end
				default: begin
					o.cls = c;
					o.status = ST_NOT_FOUND;
					for (k = 0; k < fill(c); k++) begin
						e = c ? queue_p[k] : queue_n[k];
						if (e.num == n) break;
					end
					if (k < fill(c)) begin
						o.status = ST_OK;
						o.num = e.num;
						o.tm = e.tm;
						if (act == ACT_CANCEL) begin
							if (c) queue_p.delete(k);
							else queue_n.delete(k);
							cancelled++;
						end
					end
				end
			endcase
			o.n_wait = WAIT_W'(queue_n.size());
			o.p_wait = WAIT_W'(queue_p.size());
			o.served = served;
			o.served_n = served_n;
			o.served_p = served_p;
			o.cancelled = cancelled;
			pending.push_back(o);
		endfunction

		function void check_response(outcome_t got);
			outcome_t want;
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected response at %0t", $realtime);
				return;
			end
			want = pending.pop_front();
			if (want !== got) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch at %0t: expected %p, got %p", $realtime, want, got);
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	tcq_req_if request();
	tcq_rsp_if response();
	tcq_cfg_if cfg();
	ticket_scoreboard board;

	int send_idle_pct, recv_stall_pct;
	int hold_off_cycles;
	int quiet_cycles;
	bit hold_off_active;

	two_class_ticket_queue_scheduler_core i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.request(request.source),
		.response(response.sink),
		.cfg(cfg.source)
	);

	always #5 clk = ~clk;

	// Response side: sample at the rising edge, move ready at the falling one.
	always @(posedge clk) begin
		outcome_t got;
		if (arst_n && response.valid && response.ready) begin
			got.status = status_t'(response.status);
			got.cls = response.result_class;
			got.num = response.result_number;
			got.tm = response.result_time;
			got.n_wait = response.normal_waiting;
			got.p_wait = response.preferential_waiting;
			got.served = response.served_count;
			got.served_n = response.served_normal_count;
			got.served_p = response.served_preferential_count;
			got.cancelled = response.cancelled_count;
			board.check_response(got);
		end
	end

	// Once started, the long hold-off counts its own cycles here.
	always @(negedge clk) begin
		if (!arst_n) begin
			response.ready <= 1'b0;
		end else if (hold_off_active && hold_off_cycles < HOLD_OFF_LEN) begin
			hold_off_cycles <= hold_off_cycles + 1;
			response.ready <= 1'b0;
		end else begin
			response.ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Watchdog on cycles without any accepted request or response.
	always @(posedge clk) begin
		if ((request.valid && request.ready) || (response.valid && response.ready)
				|| (hold_off_active && hold_off_cycles < HOLD_OFF_LEN))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles > WATCHDOG_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	task automatic send_request(action_t act, logic c, logic [NUM_W-1:0] n,
			logic [TOD_W-1:0] tod);
		while ($urandom_range(99) < send_idle_pct) @(negedge clk);
		request.valid = 1'b1;
		request.action = act;
		request.ticket_class = c;
		request.ticket_number = n;
		request.time_of_day = tod;
		do @(posedge clk); while (!request.ready);
		board.note_request(act, c, n, tod);
		@(negedge clk);
		request.valid = 1'b0;
	endtask

	task automatic drain();
		while (board.pending.size() != 0) @(negedge clk);
		// Search and cancel may scan a full queue.
		repeat (2 * DEPTH + 20) @(negedge clk);
	endtask

	task automatic write_burst(logic [BURST_W-1:0] value);
		cfg.valid = 1'b1;
		cfg.data = value;
		do @(posedge clk); while (!cfg.ready);
		board.burst = value;
		@(negedge clk);
		cfg.valid = 1'b0;
	endtask

	// Picks a number near the live tickets of a class so that lookups often hit.
	function automatic logic [NUM_W-1:0] pick_number(logic c);
		int sz;
		sz = board.fill(c);
		if (sz != 0 && $urandom_range(3) != 0)
			return c ? board.queue_p[$urandom_range(sz - 1)].num
				: board.queue_n[$urandom_range(sz - 1)].num;
		return $urandom_range(3) == 0 ? NUM_W'($urandom) : NUM_W'($urandom_range(300));
	endfunction

	task automatic random_requests(int count, int issue_weight);
		action_t act;
		logic c;
		int r;
		repeat (count) begin
			r = $urandom_range(99);
			if (r < issue_weight) act = ACT_ISSUE;
			else if (r < issue_weight + (100 - issue_weight) / 2) act = ACT_CALL;
			else act = $urandom_range(1) ? ACT_SEARCH : ACT_CANCEL;
			c = 1'($urandom_range(1));
			send_request(act, c, pick_number(c), TOD_W'($urandom));
		end
	endtask

	initial begin
		int i;
		request.valid = 1'b0;
		request.action = ACT_ISSUE;
		request.ticket_class = CLS_NORMAL;
		request.ticket_number = '0;
		request.time_of_day = '0;
		cfg.valid = 1'b0;
		cfg.data = '0;
		board = new();
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_off_active = 1'b0;
		repeat (3) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed: empty call, misses, field extremes, burst behavior.
		send_request(ACT_CALL, CLS_PREF, 16'd0, '0);
		send_request(ACT_SEARCH, CLS_NORMAL, 16'd0, '0);
		send_request(ACT_CANCEL, CLS_PREF, 16'hFFFF, '1);
		send_request(ACT_ISSUE, CLS_NORMAL, 16'hFFFF, '1);
		send_request(ACT_ISSUE, CLS_NORMAL, 16'd0, 17'd86399);
		send_request(ACT_ISSUE, CLS_NORMAL, 16'd0, 17'd0);
		send_request(ACT_ISSUE, CLS_PREF, 16'd0, 17'h15555);
		send_request(ACT_ISSUE, CLS_PREF, 16'd0, 17'h0AAAA);
		send_request(ACT_SEARCH, CLS_NORMAL, 16'd2, '0);
		send_request(ACT_SEARCH, CLS_PREF, 16'd0, '0);
		send_request(ACT_CANCEL, CLS_NORMAL, 16'd2, '0);
		send_request(ACT_CANCEL, CLS_NORMAL, 16'd2, '0);
		for (i = 0; i < 5; i++) send_request(ACT_CALL, CLS_NORMAL, '0, '0);
		drain();

		// Fill a queue to the top, overflow it, then search, cancel and call from it.
		write_burst(4'd0);
		send_idle_pct = 0;
		for (i = 0; i < DEPTH + 2; i++)
			send_request(ACT_ISSUE, CLS_PREF, '0, TOD_W'($urandom));
		send_request(ACT_ISSUE, CLS_NORMAL, '0, '1);
		send_request(ACT_ISSUE, CLS_NORMAL, '0, '0);
		send_request(ACT_SEARCH, CLS_PREF, 16'd128, '0);
		send_request(ACT_CANCEL, CLS_PREF, 16'd1, '0);
		for (i = 0; i < 4; i++) send_request(ACT_CALL, CLS_NORMAL, '0, '0);

		// Long receiver hold-off while requests keep coming.
		hold_off_active = 1'b1;
		random_requests(30, 50);
		while (board.pending.size() != 0) @(negedge clk);

		for (i = 0; i < DEPTH + 4; i++) send_request(ACT_CALL, CLS_NORMAL, '0, '0);
		drain();

		write_burst(4'd15);
		send_idle_pct = 76;
		random_requests(250, 45);
		drain();

		write_burst(4'd1);
		send_idle_pct = 0;
		recv_stall_pct = 76;
		random_requests(250, 40);
		drain();

		write_burst(4'($urandom_range(15)));
		send_idle_pct = 7;
		recv_stall_pct = 7;
		random_requests(250, 45);
		drain();

		write_burst(4'd3);
		send_idle_pct = 0;
		recv_stall_pct = 0;
		random_requests(100, 40);
		drain();

		if (board.mismatches == 0 && board.pending.size() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end
endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/tcq_pkg.sv
rtl/tcq_req_if.sv
rtl/tcq_rsp_if.sv
rtl/tcq_cfg_if.sv
rtl/tcq_mem.sv
rtl/two_class_ticket_queue_scheduler_core.sv
sim/tb_two_class_ticket_queue_scheduler_core.sv
